FILE: hdl/rmts_pkg.sv
// Package for the rate-monotonic tick scheduler.
// Holds field widths, register indexes and the structs shared by the modules.
// No dependencies.
package rmts_pkg;

    localparam int TASK_W = 2;
    localparam int DATA_W = 16;
    localparam int CNT_W = 3;
    localparam int POS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_TASKS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURST3 = 3'd7;

    typedef struct packed {
        logic              run;
        logic [TASK_W-1:0] task_id;
    } pick_t;

    typedef struct packed {
        logic              block_end;
        logic [TASK_W-1:0] block_task;
        logic              block_idle;
    } stats_t;

    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              tick_idle;
        logic              block_end;
        logic [TASK_W-1:0] block_task;
        logic              block_idle;
    } result_t;

endpackage

FILE: hdl/rmts_ifs.sv
// Handshake channels of the rate-monotonic tick scheduler.
// Depends on rmts_pkg for the field widths.
interface rmts_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rmts_result_if;
    logic                        valid;
    logic                        ready;
    logic [rmts_pkg::TASK_W-1:0] running_task;
    logic                        tick_idle;
    logic                        block_end;
    logic [rmts_pkg::TASK_W-1:0] block_task;
    logic                        block_idle;

    modport source (output valid, output running_task, output tick_idle, output block_end,
                    output block_task, output block_idle, input ready);
    modport sink (input valid, input running_task, input tick_idle, input block_end,
                  input block_task, input block_idle, output ready);
endinterface

FILE: hdl/rate_monotonic_tick_scheduler_unit.sv
// Top level of the rate-monotonic tick scheduler.
// Depends on rmts_pkg, the channel interfaces in rmts_ifs and rmts_stats.
//
// Each accepted word on the tick channel is one time tick and yields exactly one result
// word in the next cycle. It takes a tick in every clock cycle: the phase counters,
// release logic, priority pick and block statistics all settle combinationally between
// the state registers and the result register, and a new tick is accepted whenever the
// result register is empty or being drained. Tasks must be configured in ascending period
// order, task 0 having the highest priority. Registers 0 to 3 hold the periods, 4 to 7 the
// bursts; write them only while no tick is in flight.
module rate_monotonic_tick_scheduler_unit #(
    parameter int TASKS = 4,
    parameter int BLOCK_TICKS = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rmts_tick_if.sink                      tick,
    rmts_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmts_pkg::DATA_W-1:0]    cfg_data
);

    logic [rmts_pkg::DATA_W-1:0] period_reg [rmts_pkg::MAX_TASKS];
    logic [rmts_pkg::DATA_W-1:0] burst_reg [rmts_pkg::MAX_TASKS];
    logic [rmts_pkg::DATA_W-1:0] phase_reg [TASKS];
    logic [rmts_pkg::DATA_W-1:0] phase_next [TASKS];
    logic [rmts_pkg::DATA_W-1:0] rem_reg [TASKS];
    logic [rmts_pkg::DATA_W-1:0] rem_next [TASKS];
    logic [rmts_pkg::DATA_W-1:0] phase_eff;
    logic [rmts_pkg::DATA_W-1:0] period_eff;
    logic [rmts_pkg::DATA_W:0]   phase_inc;
    logic                        out_valid_reg;
    rmts_pkg::result_t           res_reg;
    rmts_pkg::result_t           res_next;
    rmts_pkg::pick_t             pick;
    rmts_pkg::stats_t            stats;
    logic                        step;

    assign tick.ready = !out_valid_reg || result.ready;
    assign step = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rmts_pkg::MAX_TASKS; i++)
            begin
                period_reg[i] <= rmts_pkg::DATA_W'(1);
                burst_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                [rmts_pkg::REG_PERIOD0:rmts_pkg::REG_PERIOD3]:
                    period_reg[cfg_index[1:0]] <= cfg_data;
                [rmts_pkg::REG_BURST0:rmts_pkg::REG_BURST3]:
                    burst_reg[cfg_index[1:0]] <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        pick = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            phase_eff = tick.restart ? '0 : phase_reg[i];
            rem_next[i] = tick.restart ? '0 : rem_reg[i];
            if (phase_eff == '0)
            begin
                rem_next[i] = burst_reg[i];
            end
            if (!pick.run && rem_next[i] != '0)
            begin
                pick.run = 1'b1;
                pick.task_id = rmts_pkg::TASK_W'(i);
                rem_next[i] = rem_next[i] - 1'b1;
            end
            period_eff = (period_reg[i] == '0) ? rmts_pkg::DATA_W'(1) : period_reg[i];
            phase_inc = {1'b0, phase_eff} + 1'b1;
            phase_next[i] = (phase_inc >= {1'b0, period_eff}) ? '0
                                                               : phase_inc[rmts_pkg::DATA_W-1:0];
        end
        res_next.running_task = pick.run ? pick.task_id : '0;
        res_next.tick_idle = !pick.run;
        res_next.block_end = stats.block_end;
        res_next.block_task = stats.block_task;
        res_next.block_idle = stats.block_idle;
    end

    rmts_stats #(
        .TASKS       (TASKS),
        .BLOCK_TICKS (BLOCK_TICKS)
    ) u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .restart (tick.restart),
        .pick    (pick),
        .stats   (stats)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TASKS; i++)
            begin
                phase_reg[i] <= '0;
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < TASKS; i++)
                begin
                    phase_reg[i] <= phase_next[i];
                    rem_reg[i] <= rem_next[i];
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.running_task = res_reg.running_task;
    assign result.tick_idle = res_reg.tick_idle;
    assign result.block_end = res_reg.block_end;
    assign result.block_task = res_reg.block_task;
    assign result.block_idle = res_reg.block_idle;

    // An idle tick reports task zero.
    a_idle_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.tick_idle) |-> result.running_task == '0)
        else $error("idle tick carries a running task");

    // A held result blocks the tick channel.
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !tick.ready)
        else $error("tick accepted while a result is held");

    // A tick after a restart releases every enabled task, so task 0 runs if it has a burst.
    a_restart_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tick.restart && burst_reg[0] != '0) |=>
            (!res_reg.tick_idle && res_reg.running_task == '0))
        else $error("restart tick did not run task 0");

endmodule

FILE: hdl/rmts_stats.sv
// Block statistics of the rate-monotonic tick scheduler.
// Counts the ticks each task runs within a block and finds the most-run task.
// Depends on rmts_pkg.
module rmts_stats #(
    parameter int TASKS = 4,
    parameter int BLOCK_TICKS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 restart,
    input  rmts_pkg::pick_t      pick,
    output rmts_pkg::stats_t     stats
);

    logic [rmts_pkg::CNT_W-1:0] count_reg [TASKS];
    logic [rmts_pkg::CNT_W-1:0] count_next [TASKS];
    logic [rmts_pkg::POS_W-1:0] pos_reg;
    logic [rmts_pkg::POS_W-1:0] pos_next;
    logic [rmts_pkg::POS_W-1:0] pos_eff;
    logic                       ending;
    logic [rmts_pkg::CNT_W-1:0] best;
    logic                       found;
    logic [rmts_pkg::TASK_W-1:0] best_task;
    logic [rmts_pkg::CNT_W-1:0] cnt_eff [TASKS];

    always_comb
    begin
        pos_eff = restart ? '0 : pos_reg;
        ending = ({1'b0, pos_eff} + 1'b1) >= (rmts_pkg::POS_W + 1)'(BLOCK_TICKS);
        best = '0;
        found = 1'b0;
        best_task = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            cnt_eff[i] = restart ? '0 : count_reg[i];
            if (pick.run && pick.task_id == rmts_pkg::TASK_W'(i))
            begin
                cnt_eff[i] = cnt_eff[i] + 1'b1;
            end
            if (cnt_eff[i] > best)
            begin
                best = cnt_eff[i];
                best_task = rmts_pkg::TASK_W'(i);
                found = 1'b1;
            end
            count_next[i] = ending ? '0 : cnt_eff[i];
        end
        pos_next = ending ? '0 : pos_eff + 1'b1;
        stats.block_end = ending;
        stats.block_task = (ending && found) ? best_task : '0;
        stats.block_idle = ending && !found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < TASKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            for (int i = 0; i < TASKS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // The block position never reaches the block length.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < (rmts_pkg::POS_W + 1)'(BLOCK_TICKS))
        else $error("block position out of range");

    // A restart tick always lands on the first position of a block.
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (step && restart && BLOCK_TICKS > 1) |=> pos_reg == rmts_pkg::POS_W'(1))
        else $error("restart did not reset the block position");

    // An idle block reports task zero.
    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        stats.block_idle |-> (stats.block_end && stats.block_task == '0))
        else $error("idle block carries a task");

endmodule
